/* hdl/unmultiply_pixel_unit_assert.svh */
// Assertion macros for the unmultiply pixel unit.
`ifndef UNMULTIPLY_PIXEL_UNIT_ASSERT_SVH
`define UNMULTIPLY_PIXEL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define UPX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upx assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define UPX_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("upx assertion failed");

`else

`define UPX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UPX_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons)

`endif

`endif

/* hdl/upx_pkg.sv */
// Shared types, constants and the divider step function of the unmultiply pixel unit.
`timescale 1ns / 1ps

package upx_pkg;

    localparam int CHANNELS            = 3;
    localparam int DIV_STAGES          = 4;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int SIDE_W              = CHANNELS * 8 + 1;
    // Premultiply, max, color divide, alpha select, alpha divide, output register.
    localparam int PIPE_LATENCY        = 4 + 2 * DIV_STAGES;

    typedef logic [7:0] t_chan;

    // Working state of one restoring division lane.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] lo;
        logic [7:0] quo;
    } t_div_state;

    // One restoring step: bring down the next dividend bit and try a subtract.
    // The remainder stays below the divisor, so it always fits in eight bits.
    function automatic t_div_state div_step(input t_div_state st, input t_chan den);
        logic [8:0] x;
        logic [8:0] d;
        t_div_state res;
        x = {st.rem, st.lo[7]};
        d = x - {1'b0, den};
        res.lo = {st.lo[6:0], 1'b0};
        if (x >= {1'b0, den}) begin
            res.rem = d[7:0];
            res.quo = {st.quo[6:0], 1'b1};
        end else begin
            res.rem = x[7:0];
            res.quo = {st.quo[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* hdl/upx_div.sv */
// Pipelined restoring divider of a 16-bit dividend by an 8-bit divisor, 8-bit quotient.
`timescale 1ns / 1ps

module upx_div import upx_pkg::*; #(
    parameter int LANES  = 3,
    parameter int SIDE_W = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_num [LANES],
    input  t_chan             i_den [LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_chan             o_quo [LANES],
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid [DIV_STAGES];
    t_div_state        r_st    [DIV_STAGES][LANES];
    t_chan             r_den   [DIV_STAGES][LANES];
    logic [SIDE_W-1:0] r_side  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic              v_in;
        logic [SIDE_W-1:0] side_in;
        t_div_state        st_in  [LANES];
        t_chan             den_in [LANES];
        t_div_state        n_st   [LANES];

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                // The quotient is known to fit in eight bits, so the upper
                // dividend byte is already a valid partial remainder.
                assign st_in[l]  = {i_num[l], 8'h00};
                assign den_in[l] = i_den[l];
            end
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign side_in = r_side[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign st_in[l]  = r_st[s-1][l];
                assign den_in[l] = r_den[s-1][l];
            end
        end

        always_comb begin
            t_div_state st;
            for (int l = 0; l < LANES; l++) begin
                st = st_in[l];
                for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
                    st = div_step(st, den_in[l]);
                end
                n_st[l] = st;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= side_in;
            for (int l = 0; l < LANES; l++) begin
                r_st[s][l]  <= n_st[l];
                r_den[s][l] <= den_in[l];
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_st[DIV_STAGES-1][l].quo;
    end

endmodule

/* hdl/unmultiply_pixel_unit.sv */
// Unmultiply pixel unit: scales an RGBA8 pixel so its brightest color reaches 255.
// Steps: premultiply, max, color divide, alpha select, alpha divide, output register.
// Throughput: one word per cycle while busy is low; two quotient bits per divider stage.
// Reset: synchronous, active low; clears all valid bits, busy is high while reset is held.
// The receiver cannot stall, so nothing holds a result in the output register.
`timescale 1ns / 1ps

module unmultiply_pixel_unit import upx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_chan i_in_red,
    input  t_chan i_in_green,
    input  t_chan i_in_blue,
    input  t_chan i_in_alpha,
    output logic  o_strobe,
    output t_chan o_out_red,
    output t_chan o_out_green,
    output t_chan o_out_blue,
    output t_chan o_out_alpha
);

`include "unmultiply_pixel_unit_assert.svh"

    assign busy = ~i_rst_n;

    // Stage 1: premultiply by alpha unless the pixel is opaque.
    t_chan       in_c [CHANNELS];
    logic [15:0] prod [CHANNELS];
    t_chan       n_c1 [CHANNELS];
    logic        r_v1;
    t_chan       r_c1 [CHANNELS];

    assign in_c[0] = i_in_red;
    assign in_c[1] = i_in_green;
    assign in_c[2] = i_in_blue;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            prod[i] = {8'h00, in_c[i]} * {8'h00, i_in_alpha};
            n_c1[i] = (i_in_alpha != 8'hFF) ? prod[i][15:8] : in_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= n_c1;
    end

    // Stage 2: largest channel and the dividends c * 255.
    t_chan       n_m2;
    logic [15:0] n_n2 [CHANNELS];
    logic        r_v2;
    t_chan       r_m2;
    t_chan       r_c2 [CHANNELS];
    logic [15:0] r_n2 [CHANNELS];

    always_comb begin
        n_m2 = r_c1[0];
        for (int i = 1; i < CHANNELS; i++) begin
            if (r_c1[i] > n_m2) begin
                n_m2 = r_c1[i];
            end
        end
        for (int i = 0; i < CHANNELS; i++) begin
            n_n2[i] = {r_c1[i], 8'h00} - {8'h00, r_c1[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2 <= n_m2;
        r_c2 <= r_c1;
        r_n2 <= n_n2;
    end

    // Color divider: t = c * 255 / m for all three channels.
    t_chan             den1 [CHANNELS];
    logic [SIDE_W-1:0] side1_in;
    logic              v1_out;
    t_chan             t1   [CHANNELS];
    logic [SIDE_W-1:0] side1_out;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            den1[i] = r_m2;
        end
    end

    assign side1_in = {r_c2[0], r_c2[1], r_c2[2], (r_m2 == 8'd0)};

    upx_div #(
        .LANES  (CHANNELS),
        .SIDE_W (SIDE_W)
    ) u_div_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_num   (r_n2),
        .i_den   (den1),
        .i_side  (side1_in),
        .o_valid (v1_out),
        .o_quo   (t1),
        .o_side  (side1_out)
    );

    // Alpha select: first channel with nonzero scaled value, else blue, feeds alpha divide.
    t_chan       c6 [CHANNELS];
    logic        z6;
    t_chan       sel_c;
    t_chan       sel_t;
    logic        r_v7;
    logic        r_z7;
    t_chan       r_t7   [CHANNELS];
    logic [15:0] r_anum [1];
    t_chan       r_aden [1];

    assign c6[0] = side1_out[SIDE_W-1 -: 8];
    assign c6[1] = side1_out[SIDE_W-9 -: 8];
    assign c6[2] = side1_out[SIDE_W-17 -: 8];
    assign z6    = side1_out[0];

    always_comb begin
        if (t1[0] != 8'd0) begin
            sel_c = c6[0];
            sel_t = t1[0];
        end else if (t1[1] != 8'd0) begin
            sel_c = c6[1];
            sel_t = t1[1];
        end else begin
            sel_c = c6[2];
            sel_t = t1[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= v1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z7      <= z6;
        r_t7      <= t1;
        r_anum[0] <= {sel_c, 8'h00} - {8'h00, sel_c};
        r_aden[0] <= sel_t;
    end

    // Alpha divider: alpha = c * 255 / t.
    logic              v2_out;
    t_chan             alpha_q [1];
    logic [SIDE_W-1:0] side2_out;

    upx_div #(
        .LANES  (1),
        .SIDE_W (SIDE_W)
    ) u_div_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_num   (r_anum),
        .i_den   (r_aden),
        .i_side  ({r_t7[0], r_t7[1], r_t7[2], r_z7}),
        .o_valid (v2_out),
        .o_quo   (alpha_q),
        .o_side  (side2_out)
    );

    // Output register; an all-black pixel forces every field to zero.
    logic  r_strobe;
    t_chan r_out_red;
    t_chan r_out_green;
    t_chan r_out_blue;
    t_chan r_out_alpha;
    logic  z11;

    assign z11 = side2_out[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v2_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_red   <= z11 ? 8'd0 : side2_out[SIDE_W-1 -: 8];
        r_out_green <= z11 ? 8'd0 : side2_out[SIDE_W-9 -: 8];
        r_out_blue  <= z11 ? 8'd0 : side2_out[SIDE_W-17 -: 8];
        r_out_alpha <= z11 ? 8'd0 : alpha_q[0];
    end

    assign o_strobe    = r_strobe;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

    logic out_black;
    logic out_full;

    assign out_black = (o_out_red == 8'd0) && (o_out_green == 8'd0) && (o_out_blue == 8'd0);
    assign out_full  = (o_out_red == 8'hFF) || (o_out_green == 8'hFF) || (o_out_blue == 8'hFF);

    `UPX_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, PIPE_LATENCY, o_strobe)
    `UPX_ASSERT_IMP(a_zero_alpha, i_clk, i_rst_n, o_strobe && (o_out_alpha == 8'd0), out_black)
    `UPX_ASSERT_IMP(a_full_scale, i_clk, i_rst_n, o_strobe && (o_out_alpha != 8'd0), out_full)

endmodule
